// ===== sv/bsc_pkg.sv =====
// Types and constants shared by the barometric compensation pipeline.
package bsc_pkg;

    localparam int RAW_W  = 24;
    localparam int PROM_W = 16;
    localparam int IDX_W  = 3;
    localparam int DT_W   = RAW_W + 1;
    localparam int MT_W   = DT_W + PROM_W + 1;
    localparam int SQ_W   = 2 * DT_W;
    localparam int T_W    = 20;
    localparam int OC_W   = 40;
    localparam int SPLIT  = 20;
    localparam int PLO_W  = RAW_W + SPLIT;
    localparam int PHI_W  = RAW_W + 1 + OC_W - SPLIT;
    localparam int PR_W   = 64;
    localparam int PM_SH  = 21;
    localparam int Q_W    = PR_W - PM_SH;
    localparam int X_W    = Q_W + 1;
    localparam int PD_SH  = 15;
    localparam int P_W    = 32;

    localparam int C5_SH   = 8;
    localparam int C2_SH   = 16;
    localparam int C1_SH   = 15;
    localparam int TEMP_SH = 23;
    localparam int OFF_SH  = 7;
    localparam int SENS_SH = 8;
    localparam int TSQ_SH  = 31;

    localparam logic signed [T_W-1:0] T_REF  = 20'sd2000;
    localparam logic signed [T_W-1:0] T_DEEP = -20'sd1500;

    typedef enum logic [IDX_W-1:0] {
        PROM_C1 = 3'd0,
        PROM_C2 = 3'd1,
        PROM_C3 = 3'd2,
        PROM_C4 = 3'd3,
        PROM_C5 = 3'd4,
        PROM_C6 = 3'd5
    } t_prom_idx;

    typedef struct packed {
        logic [PROM_W-1:0] c1;
        logic [PROM_W-1:0] c2;
        logic [PROM_W-1:0] c3;
        logic [PROM_W-1:0] c4;
        logic [PROM_W-1:0] c5;
        logic [PROM_W-1:0] c6;
    } t_prom;

    typedef struct packed {
        logic [RAW_W-1:0] pressure_raw;
        logic [RAW_W-1:0] raw_temperature;
    } t_in;

    typedef struct packed {
        logic signed [P_W-1:0] pressure_out;
        logic signed [T_W-1:0] temperature_centi;
        logic                  coefficients_invalid;
    } t_out;

    typedef struct packed {
        logic [RAW_W-1:0]       d1;
        logic signed [T_W-1:0]  temp;
        logic signed [OC_W-1:0] off;
        logic signed [OC_W-1:0] sens;
        logic signed [T_W-1:0]  tcorr;
        logic                   invalid;
    } t_front;

    typedef struct packed {
        logic [RAW_W-1:0]       d1;
        logic signed [T_W-1:0]  temp;
        logic signed [OC_W-1:0] off;
        logic signed [OC_W-1:0] sens;
        logic                   invalid;
    } t_corr;

endpackage

// ===== sv/bsc_front.sv =====
// First-order stages: dT, calibration products, first-order TEMP, OFF and SENS, and the dT squared term.
module bsc_front import bsc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_prom  i_prom,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_in    i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_front o_data
);

    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    logic signed [DT_W-1:0] r_dt;
    logic [RAW_W-1:0]       r_d1_1, r_d1_2;
    logic                   r_inv_1, r_inv_2;
    logic signed [MT_W-1:0] r_mt, r_mo, r_ms;
    logic signed [SQ_W-1:0] r_mq;
    t_front                 r_out;

    logic signed [DT_W-1:0]         n_dt;
    logic                           n_inv;
    logic signed [MT_W-1:0]         w_mt_b, w_mo_b, w_ms_b;
    logic signed [MT_W-TEMP_SH-1:0] w_qt;
    logic signed [MT_W-OFF_SH-1:0]  w_qo;
    logic signed [MT_W-SENS_SH-1:0] w_qs;
    t_front                         n_out;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_out;

    assign n_dt  = $signed({1'b0, i_data.raw_temperature})
                 - $signed({1'b0, i_prom.c5, {C5_SH{1'b0}}});
    assign n_inv = (i_prom.c1 == '0) || (i_prom.c2 == '0)
                || (i_prom.c5 == '0) || (i_prom.c6 == '0);

    // truncate toward zero: bias negatives before the shift
    assign w_mt_b = r_mt + (r_mt[MT_W-1] ? MT_W'({TEMP_SH{1'b1}}) : '0);
    assign w_mo_b = r_mo + (r_mo[MT_W-1] ? MT_W'({OFF_SH{1'b1}}) : '0);
    assign w_ms_b = r_ms + (r_ms[MT_W-1] ? MT_W'({SENS_SH{1'b1}}) : '0);
    assign w_qt   = w_mt_b[MT_W-1:TEMP_SH];
    assign w_qo   = w_mo_b[MT_W-1:OFF_SH];
    assign w_qs   = w_ms_b[MT_W-1:SENS_SH];

    always_comb begin
        n_out         = r_out;
        n_out.d1      = r_d1_2;
        n_out.invalid = r_inv_2;
        n_out.temp    = T_W'(w_qt) + T_REF;
        n_out.off     = OC_W'(w_qo) + OC_W'($signed({1'b0, i_prom.c2, {C2_SH{1'b0}}}));
        n_out.sens    = OC_W'(w_qs) + OC_W'($signed({1'b0, i_prom.c1, {C1_SH{1'b0}}}));
        n_out.tcorr   = T_W'(r_mq[SQ_W-2:TSQ_SH]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_dt    <= n_dt;
            r_d1_1  <= i_data.pressure_raw;
            r_inv_1 <= n_inv;
        end
        if (w_rdy2) begin
            r_mt    <= r_dt * $signed({1'b0, i_prom.c6});
            r_mo    <= r_dt * $signed({1'b0, i_prom.c4});
            r_ms    <= r_dt * $signed({1'b0, i_prom.c3});
            r_mq    <= r_dt * r_dt;
            r_d1_2  <= r_d1_1;
            r_inv_2 <= r_inv_1;
        end
        if (w_rdy3) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== sv/bsc_corr.sv =====
// Second-order stages: low and very low temperature corrections.
module bsc_corr import bsc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_front i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_corr  o_data
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    t_front                 r_f1, r_f2, r_f3;
    logic                   r_low1, r_low2, r_low3;
    logic                   r_deep1, r_deep2;
    logic signed [T_W-1:0]  r_wd, r_cd;
    logic signed [OC_W-1:0] r_wd2, r_cd2;
    logic signed [OC_W-1:0] r_off2, r_sens2;
    t_corr                  r_out;

    logic signed [OC_W-1:0] n_off2, n_sens2;
    t_corr                  n_out;

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v4;
    assign o_data  = r_out;

    always_comb begin
        n_off2  = ((r_wd2 <<< 2) + r_wd2) >>> 1;
        n_sens2 = ((r_wd2 <<< 2) + r_wd2) >>> 2;
        if (r_deep2) begin
            n_off2  = n_off2 + ((r_cd2 <<< 3) - r_cd2);
            n_sens2 = n_sens2 + (((r_cd2 <<< 3) + (r_cd2 <<< 1) + r_cd2) >>> 1);
        end
    end

    always_comb begin
        n_out.d1      = r_f3.d1;
        n_out.invalid = r_f3.invalid;
        n_out.temp    = r_f3.temp;
        n_out.off     = r_f3.off;
        n_out.sens    = r_f3.sens;
        if (r_low3) begin
            n_out.temp = r_f3.temp - r_f3.tcorr;
            n_out.off  = r_f3.off - r_off2;
            n_out.sens = r_f3.sens - r_sens2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_f1    <= i_data;
            r_low1  <= i_data.temp < T_REF;
            r_deep1 <= i_data.temp < T_DEEP;
            r_wd    <= i_data.temp - T_REF;
            r_cd    <= i_data.temp - T_DEEP;
        end
        if (w_rdy2) begin
            r_f2    <= r_f1;
            r_low2  <= r_low1;
            r_deep2 <= r_deep1;
            r_wd2   <= r_wd * r_wd;
            r_cd2   <= r_cd * r_cd;
        end
        if (w_rdy3) begin
            r_f3    <= r_f2;
            r_low3  <= r_low2;
            r_off2  <= n_off2;
            r_sens2 <= n_sens2;
        end
        if (w_rdy4) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== sv/bsc_pres.sv =====
// Pressure stages: split D1 x SENS product, scaling and offset removal.
module bsc_pres import bsc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_corr i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_out  o_data
);

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    logic [PLO_W-1:0]         r_plo;
    logic signed [PHI_W-1:0]  r_phi;
    logic signed [PR_W-1:0]   r_prod;
    logic signed [Q_W-1:0]    r_q;
    logic signed [X_W-1:0]    r_x;
    logic signed [OC_W-1:0]   r_off1, r_off2, r_off3;
    logic signed [T_W-1:0]    r_t1, r_t2, r_t3, r_t4;
    logic                     r_i1, r_i2, r_i3, r_i4;
    t_out                     r_out;

    logic [SPLIT-1:0]             w_lo;
    logic signed [OC_W-SPLIT-1:0] w_hi;
    logic signed [PR_W-1:0]       w_prod_b;
    logic signed [X_W-1:0]        w_x_b;

    assign w_rdy5  = !r_v5 || i_ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v5;
    assign o_data  = r_out;

    assign w_lo     = i_data.sens[SPLIT-1:0];
    assign w_hi     = i_data.sens[OC_W-1:SPLIT];
    assign w_prod_b = r_prod + (r_prod[PR_W-1] ? PR_W'({PM_SH{1'b1}}) : '0);
    assign w_x_b    = r_x + (r_x[X_W-1] ? X_W'({PD_SH{1'b1}}) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_plo  <= i_data.d1 * w_lo;
            r_phi  <= $signed({1'b0, i_data.d1}) * w_hi;
            r_off1 <= i_data.off;
            r_t1   <= i_data.temp;
            r_i1   <= i_data.invalid;
        end
        if (w_rdy2) begin
            r_prod <= (PR_W'(r_phi) <<< SPLIT) + $signed(PR_W'(r_plo));
            r_off2 <= r_off1;
            r_t2   <= r_t1;
            r_i2   <= r_i1;
        end
        if (w_rdy3) begin
            r_q    <= w_prod_b[PR_W-1:PM_SH];
            r_off3 <= r_off2;
            r_t3   <= r_t2;
            r_i3   <= r_i2;
        end
        if (w_rdy4) begin
            r_x  <= X_W'(r_q) - X_W'(r_off3);
            r_t4 <= r_t3;
            r_i4 <= r_i3;
        end
        if (w_rdy5) begin
            r_out.pressure_out         <= P_W'($signed(w_x_b[X_W-1:PD_SH]));
            r_out.temperature_centi    <= r_t4;
            r_out.coefficients_invalid <= r_i4;
        end
    end

endmodule

// ===== sv/baro_second_order_compensation_core.sv =====
// Top level: calibration registers and the three pipeline sections.
// An accepted input beat passes through the front, corr and pressure stage registers in order.
// Throughput: one beat per cycle while the output is ready; each section's stages fill bubbles under back-pressure.
// Three multiplier stages set the depth: dT products and dT squared, the
// low-temperature squares, and the split D1 x SENS.
// Reset (synchronous, active low) clears all valid bits and the six calibration words.
module baro_second_order_compensation_core import bsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [PROM_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data
);

    t_prom  r_prom;
    logic   w_fv, w_fr, w_cv, w_cr;
    t_front w_front;
    t_corr  w_corr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prom <= '0;
        end else if (i_cfg_we) begin
            case (t_prom_idx'(i_cfg_idx))
                PROM_C1: r_prom.c1 <= i_cfg_wdata;
                PROM_C2: r_prom.c2 <= i_cfg_wdata;
                PROM_C3: r_prom.c3 <= i_cfg_wdata;
                PROM_C4: r_prom.c4 <= i_cfg_wdata;
                PROM_C5: r_prom.c5 <= i_cfg_wdata;
                PROM_C6: r_prom.c6 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    bsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prom  (r_prom),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (w_fv),
        .i_ready (w_fr),
        .o_data  (w_front)
    );

    bsc_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .o_ready (w_fr),
        .i_data  (w_front),
        .o_valid (w_cv),
        .i_ready (w_cr),
        .o_data  (w_corr)
    );

    bsc_pres u_pres (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cv),
        .o_ready (w_cr),
        .i_data  (w_corr),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fv && !w_fr |=> w_fv && $stable(w_front))
        else $error("front beat dropped or changed under stall");

    a_corr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cv && !w_cr |=> w_cv && $stable(w_corr))
        else $error("corr beat dropped or changed under stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !w_fv && !w_cv && o_in_ready)
        else $error("pipeline not empty after reset");

endmodule
